FILE: rtl/sjpc_pkg.sv
// Shared types, constants and helpers for the stepper jog position controller.
package sjpc_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int CNT_W        = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

    localparam logic [CNT_W-1:0] UPPER_RESET = 13'd5321;
    localparam logic [CNT_W-1:0] LOWER_RESET = 13'd18;

    // Register indexes on the configuration port.
    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    // Held key bits.
    localparam int H_RIGHT  = 0;
    localparam int H_UP     = 1;
    localparam int H_DOWN   = 2;
    localparam int H_LEFT   = 3;
    localparam int H_SELECT = 4;

    // Event bits.
    localparam int E_RIGHT  = 0;
    localparam int E_UP     = 1;
    localparam int E_LEFT   = 2;
    localparam int E_SELECT = 3;

    typedef enum logic [1:0] {
        MODE_CHOOSE = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_MANUAL = 2'd2,
        MODE_HOMING = 2'd3
    } mode_t;

    typedef struct packed {
        logic [4:0] held;
        logic [3:0] evt;
        logic [1:0] hold_rl;
    } key_state_t;

    typedef struct packed {
        logic             step_pulse;
        logic             direction;
        logic [CNT_W-1:0] position_count;
        logic [CNT_W-1:0] target_count;
        mode_t            mode_now;
        logic             move_busy;
        logic             two;
    } result_t;

    // Key threshold given on a 10-bit scale, rescaled to the converter width.
    function automatic int thr(input int t, input int bits);
        return (t << bits) >> 10;
    endfunction

endpackage

FILE: rtl/sjpc_keypad.sv
// Keypad ladder decoder: press and release detection for the five buttons.
module sjpc_keypad #(
    parameter int ADC_BITS = sjpc_pkg::ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0]   sample,
    input  sjpc_pkg::key_state_t  ks_cur,
    output sjpc_pkg::key_state_t  ks_new
);
    import sjpc_pkg::*;

    localparam logic [ADC_BITS-1:0] T75  = ADC_BITS'(thr(75, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T103 = ADC_BITS'(thr(103, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T200 = ADC_BITS'(thr(200, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T250 = ADC_BITS'(thr(250, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T380 = ADC_BITS'(thr(380, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T450 = ADC_BITS'(thr(450, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T550 = ADC_BITS'(thr(550, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T650 = ADC_BITS'(thr(650, ADC_BITS));
    localparam logic [ADC_BITS-1:0] T750 = ADC_BITS'(thr(750, ADC_BITS));

    logic [4:0] press;
    logic [4:0] rel;

    always_comb
    begin
        press = '0;
        if (sample < T75)
        begin
            press[H_RIGHT] = 1'b1;
        end
        else if (sample > T103 && sample < T200)
        begin
            press[H_UP] = 1'b1;
        end
        else if (sample > T250 && sample < T380)
        begin
            press[H_DOWN] = 1'b1;
        end
        else if (sample > T450 && sample < T550)
        begin
            press[H_LEFT] = 1'b1;
        end
        else if (sample > T650 && sample < T750)
        begin
            press[H_SELECT] = 1'b1;
        end

        // The release range of a key never overlaps its own press range, so
        // the old held bit decides a release.
        rel[H_RIGHT]  = (sample > T75)  && ks_cur.held[H_RIGHT];
        rel[H_UP]     = (sample > T200) && ks_cur.held[H_UP];
        rel[H_DOWN]   = (sample > T380) && ks_cur.held[H_DOWN];
        rel[H_LEFT]   = (sample > T550) && ks_cur.held[H_LEFT];
        rel[H_SELECT] = (sample > T750) && ks_cur.held[H_SELECT];

        ks_new.held = (ks_cur.held | press) & ~rel;

        ks_new.evt = ks_cur.evt;
        ks_new.evt[E_RIGHT]  = ks_cur.evt[E_RIGHT]  | rel[H_RIGHT];
        ks_new.evt[E_UP]     = ks_cur.evt[E_UP]     | rel[H_UP];
        ks_new.evt[E_LEFT]   = ks_cur.evt[E_LEFT]   | rel[H_LEFT];
        ks_new.evt[E_SELECT] = ks_cur.evt[E_SELECT] | rel[H_SELECT];

        ks_new.hold_rl[0] = (ks_cur.hold_rl[0] | press[H_RIGHT]) & ~rel[H_RIGHT];
        ks_new.hold_rl[1] = (ks_cur.hold_rl[1] | press[H_LEFT])  & ~rel[H_LEFT];
    end

endmodule

FILE: rtl/sjpc_ctrl.sv
// Controller state registers and the single-pass next-state logic for one tick.
module sjpc_ctrl #(
    parameter int ADC_BITS = sjpc_pkg::ADC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [ADC_BITS-1:0]       sample,
    input  logic                      rfree,
    input  logic                      lfree,
    input  logic [sjpc_pkg::CNT_W-1:0] upper,
    input  logic [sjpc_pkg::CNT_W-1:0] lower,
    output sjpc_pkg::result_t         res
);
    import sjpc_pkg::*;

    mode_t            mode_reg,  mode_next;
    logic [CNT_W-1:0] pos_reg,   pos_next;
    logic [CNT_W-1:0] tgt_reg,   tgt_next;
    key_state_t       ks_reg,    ks_next;
    logic             mov_reg,   mov_next;

    key_state_t       ks_key;
    logic [CNT_W:0]   pos_plus2;
    logic [CNT_W-1:0] mv_pos;
    logic             mv_pulse;
    logic             mv_two;
    logic             mv_dir;
    logic             hr;
    logic             hl;
    logic             pulse;
    logic             two;
    logic             dir;

    sjpc_keypad #(
        .ADC_BITS (ADC_BITS)
    ) u_keypad (
        .sample (sample),
        .ks_cur (ks_reg),
        .ks_new (ks_key)
    );

    // A move step only ever starts from the registered position and target.
    always_comb
    begin
        pos_plus2 = {1'b0, pos_reg} + (CNT_W+1)'(2);
        mv_pos    = pos_reg;
        mv_pulse  = 1'b0;
        mv_two    = 1'b0;
        mv_dir    = 1'b0;
        if (pos_reg < tgt_reg)
        begin
            mv_pos   = (pos_plus2 > {1'b0, CNT_MAX}) ? CNT_MAX : pos_plus2[CNT_W-1:0];
            mv_pulse = 1'b1;
            mv_two   = 1'b1;
            mv_dir   = 1'b1;
        end
        else if (pos_reg > tgt_reg)
        begin
            mv_pos   = pos_reg - CNT_W'(1);
            mv_pulse = 1'b1;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        tgt_next  = tgt_reg;
        ks_next   = ks_reg;
        mov_next  = mov_reg;
        pulse     = 1'b0;
        two       = 1'b0;
        dir       = 1'b0;
        hr        = 1'b0;
        hl        = 1'b0;

        if (mov_reg)
        begin
            pos_next = mv_pos;
            mov_next = (mv_pos != tgt_reg);
            pulse    = mv_pulse;
            two      = mv_two;
            dir      = mv_dir;
        end
        else if (mode_reg == MODE_HOMING && lfree)
        begin
            pulse = 1'b1;
        end
        else
        begin
            if (mode_reg == MODE_HOMING)
            begin
                pos_next  = '0;
                mode_next = MODE_CHOOSE;
            end
            ks_next = ks_key;
            if (ks_next.evt[E_SELECT])
            begin
                ks_next.evt[E_SELECT] = 1'b0;
                mode_next = MODE_CHOOSE;
            end
            if (mode_next == MODE_CHOOSE)
            begin
                if (ks_next.evt[E_RIGHT])
                begin
                    ks_next.evt[E_RIGHT] = 1'b0;
                    mode_next = MODE_AUTO;
                    tgt_next  = pos_next;
                end
                if (ks_next.evt[E_LEFT])
                begin
                    ks_next.evt[E_LEFT] = 1'b0;
                    mode_next = MODE_MANUAL;
                end
            end
            else
            begin
                // A latched right or left release only counts while that key is still held.
                if (!ks_next.hold_rl[0])
                begin
                    ks_next.evt[E_RIGHT] = 1'b0;
                end
                if (!ks_next.hold_rl[1])
                begin
                    ks_next.evt[E_LEFT] = 1'b0;
                end
                hr = ks_next.hold_rl[0] | ks_next.evt[E_RIGHT];
                hl = ks_next.hold_rl[1] | ks_next.evt[E_LEFT];
                if (mode_next == MODE_AUTO)
                begin
                    if (hr && rfree && tgt_reg < upper)
                    begin
                        if (ks_next.hold_rl[0])
                        begin
                            tgt_next = tgt_reg + CNT_W'(1);
                        end
                    end
                    else if (hl && lfree && tgt_reg > lower)
                    begin
                        if (ks_next.hold_rl[1])
                        begin
                            tgt_next = tgt_reg - CNT_W'(1);
                        end
                    end
                    else if (ks_next.evt[E_UP])
                    begin
                        ks_next.evt[E_UP] = 1'b0;
                        pos_next = mv_pos;
                        mov_next = (mv_pos != tgt_reg);
                        pulse    = mv_pulse;
                        two      = mv_two;
                        dir      = mv_dir;
                    end
                end
                else
                begin
                    if (hr && rfree && pos_reg < upper)
                    begin
                        if (ks_next.hold_rl[0])
                        begin
                            pos_next = pos_reg + CNT_W'(1);
                        end
                        pulse = 1'b1;
                        dir   = 1'b1;
                    end
                    else if (hl && lfree && pos_reg > lower)
                    begin
                        if (ks_next.hold_rl[1])
                        begin
                            pos_next = pos_reg - CNT_W'(1);
                        end
                        pulse = 1'b1;
                    end
                end
            end
        end

        res.step_pulse     = pulse;
        res.direction      = pulse & dir;
        res.position_count = pos_next;
        res.target_count   = tgt_next;
        res.mode_now       = mode_next;
        res.move_busy      = mov_next;
        res.two            = two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HOMING;
            pos_reg  <= '0;
            tgt_reg  <= '0;
            ks_reg   <= '0;
            mov_reg  <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tgt_reg  <= tgt_next;
            ks_reg   <= ks_next;
            mov_reg  <= mov_next;
        end
    end

endmodule

FILE: rtl/sjpc_outbuf.sv
// Result register: holds one tick's result and replays it for a second step pulse.
module sjpc_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sjpc_pkg::result_t res_in,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              free,
    output sjpc_pkg::result_t res_out,
    output logic              last
);
    import sjpc_pkg::*;

    logic    vld_reg,  vld_next;
    logic    two_reg,  two_next;
    result_t data_reg;

    // The buffer can take a new result once its final request is leaving.
    assign free      = !vld_reg || (!out_stall && !two_reg);
    assign out_valid = vld_reg;
    assign res_out   = data_reg;
    assign last      = !two_reg;

    always_comb
    begin
        vld_next = vld_reg;
        two_next = two_reg;
        if (load)
        begin
            vld_next = 1'b1;
            two_next = res_in.two;
        end
        else if (vld_reg && !out_stall)
        begin
            if (two_reg)
            begin
                two_next = 1'b0;
            end
            else
            begin
                vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            two_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            two_reg <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

FILE: rtl/stepper_jog_position_controller_unit.sv
// Top level of the stepper jog position controller: ports, input and config registers.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, adc_sample, *_limit_free      | into block
//  out     | out_valid, out_stall, step_pulse .. last          | out of block
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata, ... | APB slave
//
// A request waits in the input register, is evaluated in a single
// combinational pass and lands in the result register when it is taken.
// A tick yields one result, or two for a rightward move step; the result
// register then holds the input side until the second result leaves, so
// throughput is one request a cycle while out_stall is low, outside rightward moves.
// Reset puts the block in homing with position and target at zero.
// A stalled output holds the result register and, behind it, the input register.
module stepper_jog_position_controller_unit #(
    parameter int ADC_BITS = sjpc_pkg::ADC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ADC_BITS-1:0]        adc_sample,
    input  logic                       right_limit_free,
    input  logic                       left_limit_free,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       step_pulse,
    output logic                       direction,
    output logic [sjpc_pkg::CNT_W-1:0] position_count,
    output logic [sjpc_pkg::CNT_W-1:0] target_count,
    output logic [1:0]                 mode_now,
    output logic                       move_busy,
    output logic                       last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import sjpc_pkg::*;

    logic                in_vld_reg;
    logic [ADC_BITS-1:0] sample_reg;
    logic                rfree_reg;
    logic                lfree_reg;
    logic [CNT_W-1:0]    upper_reg;
    logic [CNT_W-1:0]    lower_reg;
    logic                take;
    logic                ob_free;
    logic                cfg_wr;
    result_t             res;
    result_t             res_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_LOWER) ? {{(32-CNT_W){1'b0}}, lower_reg}
                                            : {{(32-CNT_W){1'b0}}, upper_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RESET;
            lower_reg <= LOWER_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_UPPER: upper_reg <= pwdata[CNT_W-1:0];
                REG_LOWER: lower_reg <= pwdata[CNT_W-1:0];
                default:   upper_reg <= upper_reg;
            endcase
        end
    end

    assign take     = in_vld_reg && ob_free;
    assign in_stall = in_vld_reg && !ob_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_vld_reg || take)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sample_reg <= adc_sample;
            rfree_reg  <= right_limit_free;
            lfree_reg  <= left_limit_free;
        end
    end

    sjpc_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .sample (sample_reg),
        .rfree  (rfree_reg),
        .lfree  (lfree_reg),
        .upper  (upper_reg),
        .lower  (lower_reg),
        .res    (res)
    );

    sjpc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_in    (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .free      (ob_free),
        .res_out   (res_out),
        .last      (last)
    );

    assign step_pulse     = res_out.step_pulse;
    assign direction      = res_out.direction;
    assign position_count = res_out.position_count;
    assign target_count   = res_out.target_count;
    assign mode_now       = res_out.mode_now;
    assign move_busy      = res_out.move_busy;

    // Only a rightward move step produces a pair of results.
    a_pair_is_right_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> step_pulse && direction)
        else $error("first of a result pair is not a right step pulse");

    // The first of a pair, once taken, is followed at once by its final twin.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last && !out_stall |=> out_valid && last && step_pulse)
        else $error("second result of a pair missing");

    // Homing never runs with a move in progress.
    a_homing_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == MODE_HOMING |-> !move_busy)
        else $error("move reported during homing");

    // No new request is evaluated while the first of a pair is still pending.
    a_no_take_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !take)
        else $error("request evaluated while a result pair is pending");

endmodule
